// ===== rtl/bldf_pkg.sv =====
package bldf_pkg;

	typedef logic [6:0]  level_t;
	typedef logic [1:0]  mode_t;
	typedef logic [2:0]  cfg_idx_t;
	typedef logic [15:0] cfg_data_t;

	// fader modes as seen on the mode output
	localparam mode_t MODE_NORMAL   = 2'd0;
	localparam mode_t MODE_BRIGHTEN = 2'd1;
	localparam mode_t MODE_DIMMING  = 2'd2;
	localparam mode_t MODE_DIM      = 2'd3;

	// configuration register indexes
	localparam cfg_idx_t REG_TARGET_LEVEL  = 3'd0;
	localparam cfg_idx_t REG_AUTO_DIM_EN   = 3'd1;
	localparam cfg_idx_t REG_DIM_LEVEL     = 3'd2;
	localparam cfg_idx_t REG_INACT_TICKS   = 3'd3;
	localparam cfg_idx_t REG_DIM_STEPS     = 3'd4;
	localparam cfg_idx_t REG_BRIGHT_STEPS  = 3'd5;

	// register reset values
	localparam level_t      RST_TARGET_LEVEL = 7'd100;
	localparam level_t      RST_DIM_LEVEL    = 7'd10;
	localparam logic [15:0] RST_INACT_TICKS  = 16'd3000;
	localparam logic [7:0]  RST_DIM_STEPS    = 8'd50;
	localparam logic [7:0]  RST_BRIGHT_STEPS = 8'd25;

	localparam int QUO_W = 7;

endpackage

// ===== rtl/backlight_auto_dim_fader.sv =====
// backlight auto-dim fader
//
// One input item is one evaluation tick carrying the activity flag; each item
// gives exactly one result item: level, level_write and mode after the tick.
// Both channels use valid/stall; in_stall is high while an item is in work.
// Configuration is written through cfg_valid/cfg_ready/cfg_index/cfg_data;
// cfg_ready is always high and writes to unknown indexes are dropped.
//
// A tick that does not start a ramp goes from accept straight to the finish state,
// where its result is loaded into the output register. A tick that starts a ramp
// first runs a restoring divide for the step (one quotient bit per cycle in a shared
// subtract/compare unit), then goes to the finish state.
// The result sits in an output register; the next tick is accepted while it
// waits. If the receiver keeps stalling, the following tick's result waits in
// the finish state and in_stall stays high until the register frees up.
// Reset loads the register defaults, normal mode, shown level 0 and clears all
// counters; no result is pending after reset.
module backlight_auto_dim_fader (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               activity,
	output logic               out_valid,
	input  logic               out_stall,
	output bldf_pkg::level_t   level,
	output logic               level_write,
	output bldf_pkg::mode_t    mode,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  bldf_pkg::cfg_idx_t cfg_index,
	input  bldf_pkg::cfg_data_t cfg_data
);
	import bldf_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	// configuration
	level_t      target_level_q;
	logic        auto_dim_en_q;
	level_t      dim_level_q;
	logic [15:0] inact_ticks_q;
	logic [7:0]  dim_steps_q;
	logic [7:0]  bright_steps_q;

	// fader state
	logic [1:0]        state_q;
	mode_t             fade_mode_q;
	logic [15:0]       idle_count_q;
	level_t            ramp_value_q;
	logic signed [8:0] ramp_step_q;
	level_t            shown_level_q;
	logic              act_latch_q;
	logic              pend_write_q;

	// divider
	logic [2:0]       div_cnt_q;
	logic [7:0]       div_rem_q;
	logic [QUO_W-1:0] div_quo_q;
	logic [7:0]       div_d_q;
	logic             div_neg_q;
	logic             div_fpos_q;

	// output register
	logic   out_valid_q;
	level_t level_q;
	logic   level_write_q;
	mode_t  mode_q;

	logic accept;
	logic act;
	logic out_free;

	// next-state of one tick
	mode_t       mode_n;
	logic [15:0] idle_n;
	level_t      ramp_n;
	level_t      shown_n;
	logic        latch_n;
	logic        write_n;
	logic        start_div;
	level_t      div_from;
	level_t      div_to;
	logic [7:0]  div_steps;
	logic        div_fpos;

	logic [15:0]       idle_inc;
	logic signed [9:0] ramp_sum;
	logic              ramp_sat;
	level_t            ramp_clamp;

	logic signed [7:0] diff;
	logic [8:0]        shifted;
	logic              div_ge;
	logic [7:0]        rem_n;
	logic [QUO_W-1:0]  quo_n;
	logic signed [8:0] step_fin;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign act       = act_latch_q | activity;

	assign out_valid   = out_valid_q;
	assign level       = level_q;
	assign level_write = level_write_q;
	assign mode        = mode_q;

	// shared ramp adder with clamp to 0..127
	assign idle_inc   = (idle_count_q == 16'hFFFF) ? idle_count_q : idle_count_q + 16'd1;
	assign ramp_sum   = $signed({3'b000, ramp_value_q}) + 10'(ramp_step_q);
	assign ramp_sat   = ramp_sum[9] || (ramp_sum > 10'sd127);
	assign ramp_clamp = ramp_sum[9] ? 7'd0 : (ramp_sat ? 7'd127 : ramp_sum[6:0]);

	always_comb begin
		mode_n    = fade_mode_q;
		idle_n    = idle_count_q;
		ramp_n    = ramp_value_q;
		shown_n   = shown_level_q;
		latch_n   = act;
		write_n   = 1'b0;
		start_div = 1'b0;
		div_from  = target_level_q;
		div_to    = dim_level_q;
		div_steps = dim_steps_q;
		div_fpos  = 1'b0;
		unique case (fade_mode_q)
			MODE_NORMAL: begin
				write_n = (shown_level_q != target_level_q);
				shown_n = target_level_q;
				if (auto_dim_en_q) begin
					if (act) begin
						latch_n = 1'b0;
						idle_n  = '0;
					end else begin
						idle_n = idle_inc;
						if (idle_inc >= inact_ticks_q) begin
							mode_n    = MODE_DIMMING;
							ramp_n    = target_level_q;
							start_div = 1'b1;
						end
					end
				end
			end
			MODE_BRIGHTEN: begin
				write_n = 1'b1;
				ramp_n  = ramp_clamp;
				if (ramp_sat || (ramp_clamp >= target_level_q)) begin
					mode_n  = MODE_NORMAL;
					idle_n  = '0;
					shown_n = target_level_q;
				end else begin
					shown_n = ramp_clamp;
				end
			end
			MODE_DIMMING: begin
				write_n = 1'b1;
				ramp_n  = ramp_clamp;
				if (ramp_sat || (ramp_clamp <= dim_level_q)) begin
					mode_n  = MODE_DIM;
					shown_n = dim_level_q;
				end else begin
					shown_n = ramp_clamp;
				end
			end
			MODE_DIM: begin
				if (act) begin
					latch_n   = 1'b0;
					mode_n    = MODE_BRIGHTEN;
					ramp_n    = dim_level_q;
					start_div = 1'b1;
					div_from  = dim_level_q;
					div_to    = target_level_q;
					div_steps = bright_steps_q;
					div_fpos  = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign diff = $signed({1'b0, div_to}) - $signed({1'b0, div_from});

	// one quotient bit per cycle
	assign shifted = {div_rem_q, div_quo_q[QUO_W-1]};
	assign div_ge  = (shifted >= {1'b0, div_d_q});
	assign rem_n   = div_ge ? 8'(shifted - {1'b0, div_d_q}) : shifted[7:0];
	assign quo_n   = {div_quo_q[QUO_W-2:0], div_ge};

	always_comb begin
		if (quo_n == '0) begin
			step_fin = div_fpos_q ? 9'sd1 : -9'sd1;
		end else if (div_neg_q) begin
			step_fin = -$signed({2'b00, quo_n});
		end else begin
			step_fin = $signed({2'b00, quo_n});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_level_q <= RST_TARGET_LEVEL;
			auto_dim_en_q  <= 1'b1;
			dim_level_q    <= RST_DIM_LEVEL;
			inact_ticks_q  <= RST_INACT_TICKS;
			dim_steps_q    <= RST_DIM_STEPS;
			bright_steps_q <= RST_BRIGHT_STEPS;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_TARGET_LEVEL: target_level_q <= cfg_data[6:0];
				REG_AUTO_DIM_EN:  auto_dim_en_q  <= cfg_data[0];
				REG_DIM_LEVEL:    dim_level_q    <= cfg_data[6:0];
				REG_INACT_TICKS:  inact_ticks_q  <= cfg_data;
				REG_DIM_STEPS:    dim_steps_q    <= cfg_data[7:0];
				REG_BRIGHT_STEPS: bright_steps_q <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			fade_mode_q   <= MODE_NORMAL;
			idle_count_q  <= '0;
			ramp_value_q  <= '0;
			ramp_step_q   <= '0;
			shown_level_q <= '0;
			act_latch_q   <= 1'b0;
			pend_write_q  <= 1'b0;
			div_cnt_q     <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						fade_mode_q   <= mode_n;
						idle_count_q  <= idle_n;
						ramp_value_q  <= ramp_n;
						shown_level_q <= shown_n;
						act_latch_q   <= latch_n;
						pend_write_q  <= write_n;
						div_cnt_q     <= '0;
						state_q       <= start_div ? ST_DIV : ST_DONE;
					end
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q + 3'd1;
					if (div_cnt_q == 3'(QUO_W - 1)) begin
						ramp_step_q <= step_fin;
						div_cnt_q   <= '0;
						state_q     <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// divider datapath and output payload
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept && start_div) begin
			div_rem_q  <= '0;
			div_quo_q  <= diff[7] ? 7'(-diff) : diff[6:0];
			div_neg_q  <= diff[7];
			div_d_q    <= (div_steps == 8'd0) ? 8'd1 : div_steps;
			div_fpos_q <= div_fpos;
		end else if (state_q == ST_DIV) begin
			div_rem_q <= rem_n;
			div_quo_q <= quo_n;
		end
		if (state_q == ST_DONE && out_free) begin
			level_q       <= shown_level_q;
			level_write_q <= pend_write_q;
			mode_q        <= fade_mode_q;
		end
	end

	// a ramp in progress always has a nonzero step once the divide is done
	a_step_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && (fade_mode_q == MODE_BRIGHTEN || fade_mode_q == MODE_DIMMING))
		|-> (ramp_step_q != 9'sd0))
		else $error("ramp running with zero step");

	a_cnt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_DIV) |-> (div_cnt_q == 3'd0))
		else $error("divide counter not cleared outside divide");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
		else $error("result loaded outside finish state");

	a_div_enters_ramp: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (fade_mode_q == MODE_BRIGHTEN || fade_mode_q == MODE_DIMMING))
		else $error("divide running outside a ramp start");

endmodule

// ===== verif/backlight_auto_dim_fader_check.sv =====
module backlight_auto_dim_fader_check (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  logic                activity,
	input  logic                out_valid,
	input  logic                out_stall,
	input  bldf_pkg::level_t    level,
	input  logic                level_write,
	input  bldf_pkg::mode_t     mode,
	input  logic                cfg_valid,
	input  logic                cfg_ready,
	input  bldf_pkg::cfg_idx_t  cfg_index,
	input  bldf_pkg::cfg_data_t cfg_data,
	output int                  fail_count,
	output int                  pending,
	output int                  n_ticks,
	output int                  n_level_writes,
	output int                  n_dim_ramps,
	output int                  n_bright_ramps,
	output int                  n_cfg_writes
);
	timeunit 1ns;
	timeprecision 1ps;
	import bldf_pkg::*;

	typedef struct packed {
		level_t lvl;
		logic   wr;
		mode_t  md;
	} fade_out_t;

	// register copies
	level_t      target_lvl;
	level_t      dim_lvl;
	logic        auto_dim_on;
	logic [15:0] idle_limit;
	logic [7:0]  dim_div;
	logic [7:0]  bright_div;

	// fader state
	mode_t       fader_mode;
	logic [15:0] idle_run;
	int          ramp_pos;
	int          ramp_inc;
	level_t      shown_lvl;
	logic        act_pending;

	fade_out_t   fader_outputs_due[$];

	// per-tick ramp increment, truncated toward zero; zero becomes the nudge
	function automatic int fade_increment(input int from_lvl, input int to_lvl,
			input int divisor, input int nudge);
		int d;
		int q;
		d = (divisor == 0) ? 1 : divisor;
		q = (to_lvl - from_lvl) / d;
		return (q == 0) ? nudge : q;
	endfunction

	// clamps to 0..127, a clamp ends the ramp
	function automatic logic ramp_advance();
		int v;
		v = ramp_pos + ramp_inc;
		ramp_pos = (v < 0) ? 0 : ((v > 127) ? 127 : v);
		return (v < 0) || (v > 127);
	endfunction

	task automatic fade_one_tick(input logic act, output fade_out_t res);
		logic wr;
		wr = 1'b0;
		if (act)
			act_pending = 1'b1;
		case (fader_mode)
		MODE_NORMAL: begin
			if (shown_lvl != target_lvl) begin
				shown_lvl = target_lvl;
				wr = 1'b1;
			end
			if (auto_dim_on) begin
				if (act_pending) begin
					act_pending = 1'b0;
					idle_run = '0;
				end else begin
					if (idle_run != 16'hFFFF)
						idle_run = idle_run + 16'd1;
					if (idle_run >= idle_limit) begin
						fader_mode = MODE_DIMMING;
						ramp_pos = int'(target_lvl);
						ramp_inc = fade_increment(int'(target_lvl), int'(dim_lvl),
							int'(dim_div), -1);
						n_dim_ramps++;
					end
				end
			end
		end
		MODE_BRIGHTEN: begin
			if (ramp_advance() || ramp_pos >= int'(target_lvl)) begin
				fader_mode = MODE_NORMAL;
				idle_run = '0;
				shown_lvl = target_lvl;
			end else begin
				shown_lvl = level_t'(ramp_pos);
			end
			wr = 1'b1;
		end
		MODE_DIMMING: begin
			if (ramp_advance() || ramp_pos <= int'(dim_lvl)) begin
				fader_mode = MODE_DIM;
				shown_lvl = dim_lvl;
			end else begin
				shown_lvl = level_t'(ramp_pos);
			end
			wr = 1'b1;
		end
		default: begin
			if (act_pending) begin
				act_pending = 1'b0;
				fader_mode = MODE_BRIGHTEN;
				ramp_pos = int'(dim_lvl);
				ramp_inc = fade_increment(int'(dim_lvl), int'(target_lvl),
					int'(bright_div), 1);
				n_bright_ramps++;
			end
		end
		endcase
		res = '{lvl: shown_lvl, wr: wr, md: fader_mode};
	endtask

	always @(posedge clk) begin
		fade_out_t due;
		fade_out_t seen;
		if (!arst_n) begin
			target_lvl = RST_TARGET_LEVEL;
			dim_lvl = RST_DIM_LEVEL;
			auto_dim_on = 1'b1;
			idle_limit = RST_INACT_TICKS;
			dim_div = RST_DIM_STEPS;
			bright_div = RST_BRIGHT_STEPS;
			fader_mode = MODE_NORMAL;
			idle_run = '0;
			ramp_pos = 0;
			ramp_inc = 0;
			shown_lvl = '0;
			act_pending = 1'b0;
			fader_outputs_due.delete();
			fail_count = 0;
			n_ticks = 0;
			n_level_writes = 0;
			n_dim_ramps = 0;
			n_bright_ramps = 0;
			n_cfg_writes = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				n_cfg_writes++;
				case (cfg_index)
				REG_TARGET_LEVEL: target_lvl = cfg_data[6:0];
				REG_AUTO_DIM_EN:  auto_dim_on = cfg_data[0];
				REG_DIM_LEVEL:    dim_lvl = cfg_data[6:0];
				REG_INACT_TICKS:  idle_limit = cfg_data;
				REG_DIM_STEPS:    dim_div = cfg_data[7:0];
				REG_BRIGHT_STEPS: bright_div = cfg_data[7:0];
				default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				seen = '{lvl: level, wr: level_write, md: mode};
				if (fader_outputs_due.size() == 0) begin
					fail_count++;
					$display("%0t: item out with none expected: level %0d write %0b mode %0d",
						$time, seen.lvl, seen.wr, seen.md);
				end else begin
					due = fader_outputs_due.pop_front();
					if (seen.lvl !== due.lvl) begin
						fail_count++;
						$display("%0t: level expected %0d got %0d", $time, due.lvl, seen.lvl);
					end
					if (seen.wr !== due.wr) begin
						fail_count++;
						$display("%0t: level_write expected %0b got %0b", $time, due.wr,
							seen.wr);
					end
					if (seen.md !== due.md) begin
						fail_count++;
						$display("%0t: mode expected %0d got %0d", $time, due.md, seen.md);
					end
				end
			end
			if (in_valid && !in_stall) begin
				fade_one_tick(activity, due);
				fader_outputs_due.push_back(due);
				n_ticks++;
				if (due.wr)
					n_level_writes++;
			end
		end
		pending <= fader_outputs_due.size();
	end

endmodule

// ===== verif/backlight_auto_dim_fader_test.sv =====
module backlight_auto_dim_fader_test;
	timeunit 1ns;
	timeprecision 1ps;
	import bldf_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int TICK_GOAL   = 1600;
	localparam int HOLD_CYCLES = 300;

	// indexes that map to no register
	localparam cfg_idx_t REG_UNMAPPED_LO = 3'd6;
	localparam cfg_idx_t REG_UNMAPPED_HI = 3'd7;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_stall;
	logic      activity = 1'b0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	level_t    level;
	logic      level_write;
	mode_t     mode;
	logic      cfg_valid = 1'b0;
	logic      cfg_ready;
	cfg_idx_t  cfg_index = '0;
	cfg_data_t cfg_data = '0;

	int fail_count;
	int pending_results;
	int n_ticks;
	int n_level_writes;
	int n_dim_ramps;
	int n_bright_ramps;
	int n_cfg_writes;

	int cycle_count = 0;
	int send_idle_pct = 18;
	int recv_idle_pct = 62;
	int hold_requests = 0;
	int ticks_sent = 0;

	backlight_auto_dim_fader dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.activity    (activity),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.level       (level),
		.level_write (level_write),
		.mode        (mode),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	backlight_auto_dim_fader_check fade_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.activity       (activity),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.level          (level),
		.level_write    (level_write),
		.mode           (mode),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.fail_count     (fail_count),
		.pending        (pending_results),
		.n_ticks        (n_ticks),
		.n_level_writes (n_level_writes),
		.n_dim_ramps    (n_dim_ramps),
		.n_bright_ramps (n_bright_ramps),
		.n_cfg_writes   (n_cfg_writes)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT)
			@(posedge clk);
		$display("%0t: timeout after %0d cycles, %0d items outstanding", $time, CYCLE_LIMIT,
			pending_results);
		$display("FAILURE");
		$finish;
	end

	// receiver: random stall, plus long hold-offs on request
	initial begin : receiver
		int served;
		int hold_left;
		served = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_requests != served) begin
				served = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	function automatic int one_of(input int a, input int b, input int c);
		case ($urandom_range(2))
		0: return a;
		1: return b;
		default: return c;
		endcase
	endfunction

	task automatic send_tick(input logic act);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			activity <= $urandom_range(1);
			@(posedge clk);
		end
		in_valid <= 1'b1;
		activity <= act;
		do @(posedge clk); while (in_stall);
		ticks_sent++;
	endtask

	// lsb first
	task automatic send_pattern(input logic [15:0] acts, input int count);
		for (int i = 0; i < count; i++)
			send_tick(acts[i]);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_results != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input int value, input int field_bits);
		cfg_data_t word;
		word = cfg_data_t'(value);
		// junk above the field width must be ignored
		if (field_bits < 16 && $urandom_range(7) == 0)
			word = word | (cfg_data_t'($urandom) << field_bits);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= word;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	initial begin : stimulus
		int regime;
		int cur_regime;
		int regime_send_pct;
		int phase;
		int n_phase_ticks;
		int act_pct;
		int pause_at;
		logic hold;
		logic extreme;
		logic all_regs;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: first write of the target, then activity
		send_pattern(16'b10, 2);
		drain_results();

		// zero divisors and zero timeout: full-swing one-tick ramps
		write_reg(REG_TARGET_LEVEL, 127, 7);
		write_reg(REG_DIM_LEVEL, 0, 7);
		write_reg(REG_INACT_TICKS, 0, 16);
		write_reg(REG_DIM_STEPS, 0, 8);
		write_reg(REG_BRIGHT_STEPS, 0, 8);
		send_pattern(16'b01000, 5);
		drain_results();

		// auto-dim off keeps the activity latched
		write_reg(REG_AUTO_DIM_EN, 0, 1);
		write_reg(REG_TARGET_LEVEL, 0, 7);
		send_pattern(16'b01, 2);
		drain_results();

		// dim above target: forced unit steps, clamped ramp
		write_reg(REG_AUTO_DIM_EN, 1, 1);
		write_reg(REG_INACT_TICKS, 1, 16);
		write_reg(REG_DIM_STEPS, 255, 8);
		write_reg(REG_BRIGHT_STEPS, 255, 8);
		write_reg(REG_DIM_LEVEL, 100, 7);
		write_reg(REG_UNMAPPED_LO, 16'hFFFF, 16);
		write_reg(REG_UNMAPPED_HI, 16'h0000, 16);
		send_pattern(16'b01000, 5);
		drain_results();

		// levels above 100, multi-tick ramps, activity while dimming
		write_reg(REG_TARGET_LEVEL, 120, 7);
		write_reg(REG_DIM_LEVEL, 110, 7);
		write_reg(REG_INACT_TICKS, 2, 16);
		write_reg(REG_DIM_STEPS, 3, 8);
		write_reg(REG_BRIGHT_STEPS, 2, 8);
		send_pattern(16'b000100000, 9);

		cur_regime = -1;
		regime_send_pct = 18;
		phase = 0;
		while (ticks_sent < TICK_GOAL) begin
			regime = ticks_sent * 3 / TICK_GOAL;
			drain_results();
			hold = (regime != cur_regime) && (regime < 2);
			if (regime != cur_regime) begin
				cur_regime = regime;
				regime_send_pct = (regime == 0) ? 18 : ((regime == 1) ? 62 : 0);
				recv_idle_pct <= (regime == 0) ? 62 : ((regime == 1) ? 18 : 0);
			end

			// settings change between phases, the fader may be mid-ramp
			all_regs = (phase == 0);
			extreme = ($urandom_range(5) == 0);
			if (all_regs || $urandom_range(1))
				write_reg(REG_TARGET_LEVEL, extreme ? one_of(0, 100, 127) :
					(($urandom_range(7) == 0) ? $urandom_range(101, 127) :
					$urandom_range(0, 100)), 7);
			if (all_regs || $urandom_range(1))
				write_reg(REG_AUTO_DIM_EN, ($urandom_range(5) != 0), 1);
			if (all_regs || $urandom_range(1))
				write_reg(REG_DIM_LEVEL, extreme ? one_of(0, 0, 127) :
					(($urandom_range(7) == 0) ? $urandom_range(0, 127) :
					$urandom_range(0, 100)), 7);
			if (all_regs || $urandom_range(1))
				write_reg(REG_INACT_TICKS, extreme ? one_of(0, 1, 65535) :
					(($urandom_range(9) == 0) ? $urandom_range(0, 60) :
					$urandom_range(0, 10)), 16);
			if (all_regs || $urandom_range(1))
				write_reg(REG_DIM_STEPS, extreme ? one_of(0, 1, 255) :
					(($urandom_range(7) == 0) ? $urandom_range(0, 255) :
					$urandom_range(0, 12)), 8);
			if (all_regs || $urandom_range(1))
				write_reg(REG_BRIGHT_STEPS, extreme ? one_of(0, 1, 255) :
					(($urandom_range(7) == 0) ? $urandom_range(0, 255) :
					$urandom_range(0, 12)), 8);

			n_phase_ticks = $urandom_range(20, 80);
			act_pct = one_of(2, 8, $urandom_range(1) ? 30 : 70);
			pause_at = (phase % 4 == 1) ? $urandom_range(1, n_phase_ticks - 1) : -1;
			// long receiver hold-off with the sender pushing back to back
			if (hold) begin
				send_idle_pct = 0;
				hold_requests <= hold_requests + 1;
			end else begin
				send_idle_pct = regime_send_pct;
			end
			for (int i = 0; i < n_phase_ticks; i++) begin
				if (i == pause_at)
					drain_results();
				send_tick($urandom_range(99) < act_pct);
			end
			phase++;
		end

		recv_idle_pct <= 0;
		drain_results();
		repeat (16) @(posedge clk);

		$display("covered %0d ticks with %0d level writes and %0d register writes",
			n_ticks, n_level_writes, n_cfg_writes);
		$display("ramps: %0d dim-down, %0d brighten, over %0d settings phases",
			n_dim_ramps, n_bright_ramps, phase);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
